/* hdl/wes_pkg.sv */
// ----------------------------------------------------------------------------
// Wheel encoder speed estimator package
// Shared widths, direction codes and the status and request structs.
// ----------------------------------------------------------------------------
package wes_pkg;

  localparam int TimeW   = 32;
  localparam int DriveW  = 16;
  localparam int StepW   = 11;
  localparam int SpeedW  = 16;
  localparam int CountW  = 12;
  localparam int DivW    = 25;
  localparam int DivCntW = 5;

  localparam logic [CountW-1:0] MinCountReset = 12'd30;

  localparam logic [1:0] DIR_STOPPED  = 2'd0;
  localparam logic [1:0] DIR_POSITIVE = 2'd1;
  localparam logic [1:0] DIR_NEGATIVE = 2'd2;

  typedef struct packed {
    logic                     need;
    logic                     neg;
    logic [SpeedW-1:0]        mag;
    logic [TimeW-1:0]         elapsed;
    logic signed [SpeedW-1:0] held;
  } wheel_stat_t;

  typedef struct packed {
    logic              neg;
    logic [SpeedW-1:0] mag;
    logic [TimeW-1:0]  divisor;
  } div_req_t;

endpackage

/* hdl/wes_wheel.sv */
// ----------------------------------------------------------------------------
// Wheel state
// Step accumulation, direction tracking and time mark for one wheel.
// ----------------------------------------------------------------------------
module wes_wheel import wes_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [TimeW-1:0]         now,
  input  logic signed [DriveW-1:0] drive,
  input  logic signed [StepW-1:0]  steps,
  input  logic [CountW-1:0]        min_count,
  input  logic                     wr,
  input  logic signed [SpeedW-1:0] wr_speed,
  output wheel_stat_t              stat
);

  logic signed [SpeedW-1:0] step_sum;
  logic [TimeW-1:0]         mark_time;
  logic [1:0]               last_dir;
  logic signed [SpeedW-1:0] held;
  logic                     need;
  logic                     neg;
  logic [SpeedW-1:0]        mag;
  logic [TimeW-1:0]         elapsed;

  logic signed [SpeedW:0]   sum_wide;
  logic signed [SpeedW-1:0] sum_sat;
  logic [1:0]               dir_new;
  logic                     restart;
  logic [SpeedW-1:0]        mag_new;
  logic                     enough;
  logic [TimeW-1:0]         dt;

  always_comb begin
    sum_wide = 17'(step_sum) + 17'(steps);
    if (sum_wide > 17'sd32767) begin
      sum_sat = 16'sh7fff;
    end else if (sum_wide < -17'sd32768) begin
      sum_sat = 16'sh8000;
    end else begin
      sum_sat = sum_wide[SpeedW-1:0];
    end
    dir_new = drive[DriveW-1] ? DIR_NEGATIVE : DIR_POSITIVE;
    restart = (drive == '0) || (dir_new != last_dir);
    mag_new = sum_sat[SpeedW-1] ? 16'(~sum_sat + 16'sd1) : sum_sat;
    enough  = mag_new >= {4'd0, min_count};
    dt      = now - mark_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_sum  <= '0;
      mark_time <= '0;
      last_dir  <= DIR_STOPPED;
      held      <= '0;
      need      <= 1'b0;
    end else if (load) begin
      if (drive != '0) begin
        last_dir <= dir_new;
      end
      if (restart) begin
        held      <= '0;
        mark_time <= now;
        step_sum  <= '0;
        need      <= 1'b0;
      end else if (enough) begin
        mark_time <= now;
        step_sum  <= '0;
        need      <= 1'b1;
      end else begin
        step_sum <= sum_sat;
        need     <= 1'b0;
      end
    end else if (wr) begin
      held <= wr_speed;
      need <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg     <= sum_sat[SpeedW-1];
      mag     <= mag_new;
      elapsed <= (dt == '0) ? 32'd1 : dt;
    end
  end

  assign stat.need    = need;
  assign stat.neg     = neg;
  assign stat.mag     = mag;
  assign stat.elapsed = elapsed;
  assign stat.held    = held;

endmodule

/* hdl/wes_div.sv */
// ----------------------------------------------------------------------------
// Bit-serial speed divider
// Scales the step magnitude by 1000 and divides it by the elapsed time,
// one quotient bit per cycle, then applies the sign and saturates.
// ----------------------------------------------------------------------------
module wes_div import wes_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  div_req_t                 req,
  output logic                     busy,
  output logic                     done,
  output logic signed [SpeedW-1:0] quotient
);

  logic [DivCntW-1:0] cnt;
  logic [TimeW-1:0]   rem;
  logic [DivW-1:0]    quo;
  logic [TimeW-1:0]   divisor;
  logic               neg;

  logic [DivW:0]      scaled;
  logic [TimeW:0]     trial;
  logic [TimeW:0]     diff;
  logic               fits;

  always_comb begin
    scaled = {req.mag, 10'd0} - {6'd0, req.mag, 4'd0} - {7'd0, req.mag, 3'd0};
    trial  = {rem, quo[DivW-1]};
    diff   = trial - {1'b0, divisor};
    fits   = trial >= {1'b0, divisor};
    if (neg) begin
      quotient = (quo > 25'd32768) ? 16'sh8000 : 16'(~quo[SpeedW-1:0] + 16'd1);
    end else begin
      quotient = (quo > 25'd32767) ? 16'sh7fff : quo[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= DivCntW'(DivW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= scaled[DivW-1:0];
      divisor <= req.divisor;
      neg     <= req.neg;
    end else if (busy) begin
      rem <= fits ? diff[TimeW-1:0] : trial[TimeW-1:0];
      quo <= {quo[DivW-2:0], fits};
    end
  end

endmodule

/* hdl/wheel_encoder_speed_estimator.sv */
// ----------------------------------------------------------------------------
// Wheel encoder speed estimator
// Per-wheel step accumulation and speed estimation with a shared divider.
// ----------------------------------------------------------------------------
// Usage: each input beat on in_valid/in_ready carries a millisecond timestamp,
// both motor drive values and the encoder steps seen per wheel since the
// previous beat. Every input beat yields exactly one output beat on
// out_valid/out_ready with both wheel speeds and their average.
// The min_step_count register is written through cfg_valid/cfg_ready with
// cfg_data; it is always ready and should be written only while idle.
// After accept, the left and then the right wheel pass the issue state; each
// wheel that needs a new speed runs the bit-serial divider, shared by both
// wheels, before the finish state loads the output register.
// One item is processed at a time; in_ready is high only while idle.
// A finished result sits in the output register, so the next input beat is
// taken while the receiver stalls; a second result then waits until the
// first is taken. Synchronous reset clears the wheel step sums, time marks,
// directions, held speeds and output valid, and sets min_step_count to 30.
// ----------------------------------------------------------------------------
module wheel_encoder_speed_estimator import wes_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CountW-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TimeW-1:0]         timestamp_ms,
  input  logic signed [DriveW-1:0] drive_left,
  input  logic signed [DriveW-1:0] drive_right,
  input  logic signed [StepW-1:0]  steps_left,
  input  logic signed [StepW-1:0]  steps_right,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SpeedW-1:0] speed_left,
  output logic signed [SpeedW-1:0] speed_right,
  output logic signed [SpeedW-1:0] speed_center
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DIV, S_FINISH} state_t;

  state_t              state;
  logic                sel;
  logic [CountW-1:0]   min_step_count;

  wheel_stat_t         stat_left;
  wheel_stat_t         stat_right;
  wheel_stat_t         cur;
  div_req_t            req;
  logic                accept;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic signed [SpeedW-1:0] div_q;
  logic signed [SpeedW:0]   pair_sum;
  logic signed [SpeedW:0]   pair_adj;
  logic signed [SpeedW-1:0] center;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    cur         = sel ? stat_right : stat_left;
    req.neg     = cur.neg;
    req.mag     = cur.mag;
    req.divisor = cur.elapsed;
    div_start   = (state == S_ISSUE) && cur.need;
    pair_sum    = 17'(stat_left.held) + 17'(stat_right.held);
    pair_adj    = pair_sum + {16'd0, pair_sum[SpeedW]};
    center      = pair_adj[SpeedW:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step_count <= MinCountReset;
    end else if (cfg_valid && cfg_ready) begin
      min_step_count <= cfg_data;
    end
  end

  wes_wheel u_left (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .now       (timestamp_ms),
    .drive     (drive_left),
    .steps     (steps_left),
    .min_count (min_step_count),
    .wr        (div_done && !sel),
    .wr_speed  (div_q),
    .stat      (stat_left)
  );

  wes_wheel u_right (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .now       (timestamp_ms),
    .drive     (drive_right),
    .steps     (steps_right),
    .min_count (min_step_count),
    .wr        (div_done && sel),
    .wr_speed  (div_q),
    .stat      (stat_right)
  );

  wes_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .req      (req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sel   <= 1'b0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (cur.need) begin
            state <= S_DIV;
          end else if (sel) begin
            state <= S_FINISH;
          end else begin
            sel <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (sel) begin
              state <= S_FINISH;
            end else begin
              sel   <= 1'b1;
              state <= S_ISSUE;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            speed_left   <= stat_left.held;
            speed_right  <= stat_right.held;
            speed_center <= center;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("Divider finished outside of the divide state.");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!div_busy && !div_done))
    else $error("Divider active while the block takes input.");

  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("Finished item did not reach the output register.");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("Divider started while still busy.");

endmodule
